// ----- src/smg_pkg.sv -----
package smg_pkg;

	localparam int MaxClasses = 64;
	localparam int IdxW = $clog2(MaxClasses);
	localparam int CntW = IdxW + 1;

	// exp(-2^(k-8)) in Q1.30, one entry per bit of the distance from the max
	function automatic logic [30:0] exp_tab(input logic [3:0] k);
		logic [30:0] r;
		begin
			case (k)
				4'd0: r = 31'd1069555701;
				4'd1: r = 31'd1065385899;
				4'd2: r = 31'd1057095000;
				4'd3: r = 31'd1040706261;
				4'd4: r = 31'd1008687096;
				4'd5: r = 31'd947573834;
				4'd6: r = 31'd836230973;
				4'd7: r = 31'd651257337;
				4'd8: r = 31'd395007542;
				4'd9: r = 31'd145315154;
				4'd10: r = 31'd19666267;
				4'd11: r = 31'd360200;
				default: r = 31'd0;
			endcase
			return r;
		end
	endfunction

	typedef struct packed {
		logic        start;
		logic [16:0] e;
		logic [22:0] sum;
	} div_req_t;

endpackage

// ----- src/smg_div.sv -----
// Restoring divider: q = floor((e*32768 + sum/2) / sum), one quotient bit per cycle
module smg_div import smg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  div_req_t    req,
	output logic        done,
	output logic [15:0] quo
);
	logic [37:0] rem_q;
	logic [32:0] num_q;
	logic [22:0] den_q;
	logic [32:0] quo_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [38:0] trial;

	assign trial = {rem_q, num_q[32]} - {16'd0, den_q};

	// shift-subtract loop over 33 numerator bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd33;
				rem_q  <= '0;
				num_q  <= {1'b0, req.e, 15'd0} + {11'd0, req.sum[22:1]};
				den_q  <= req.sum;
				quo_q  <= '0;
			end else if (busy_q) begin
				if (!trial[38]) rem_q <= trial[37:0];
				else rem_q <= {rem_q[36:0], num_q[32]};
				num_q <= {num_q[31:0], 1'b0};
				quo_q <= {quo_q[31:0], ~trial[38]};
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// saturate to Q1.15
	assign quo = (quo_q > 33'd32767) ? 16'd32767 : quo_q[15:0];
endmodule

// ----- src/softmax_with_gradient_unit.sv -----
// Row softmax and its gradient, one row element per start.
// Non-final elements are taken while busy stays low.
// A row end of n elements keeps busy high through passes over the n elements, for
// probabilities or gradients: exp, one table bit a cycle; divide, one quotient bit a cycle;
// dot product (gradients only); output, no stall.
// arst_n clears the count, max and mode; the element stores keep no reset.
module softmax_with_gradient_unit import smg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic signed [15:0] logit,
	input  logic signed [15:0] upstream_grad,
	input  logic               row_end,
	output logic               strobe,
	output logic signed [15:0] value,
	output logic               last
);
	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_EXPF = 11'b00000000010,
		S_EXP  = 11'b00000000100,
		S_EXPW = 11'b00000001000,
		S_DIVF = 11'b00000010000,
		S_DIV  = 11'b00000100000,
		S_DIVW = 11'b00001000000,
		S_DOTF = 11'b00010000000,
		S_DOT  = 11'b00100000000,
		S_OUT  = 11'b01000000000,
		S_OUTM = 11'b10000000000
	} state_t;

	state_t state_q;
	logic signed [15:0] logit_mem [MaxClasses];
	logic signed [15:0] grad_mem [MaxClasses];
	logic [16:0] e_mem [MaxClasses];
	logic [15:0] p_mem [MaxClasses];
	logic [CntW-1:0] cnt_q, n_q;
	logic [IdxW-1:0] j_q;
	logic signed [15:0] max_q;
	logic mode_q, mode_row_q;
	logic [30:0] acc_q;
	logic [15:0] a_q;
	logic [3:0]  k_q;
	logic [22:0] sum_q;
	logic signed [39:0] s_q;
	logic signed [15:0] x_q, d_q;
	logic [16:0] e_q;
	logic [15:0] p_q;
	logic signed [16:0] a_full;
	logic [61:0] prod;
	logic [30:0] acc_next;
	logic [16:0] e_new;
	logic last_el;
	div_req_t dreq;
	logic ddone;
	logic [15:0] dquo;
	logic signed [41:0] diff;
	logic signed [58:0] t;
	logic [58:0] mag;
	logic [29:0] rmag;
	logic signed [30:0] r;
	logic signed [15:0] g;

	logic acc_ok;
	assign acc_ok = start && !busy;
	assign busy = (state_q != S_IDLE);

	// current element is the last of the row
	assign last_el = (({1'b0, j_q} + CntW'(1)) == n_q);

	assign a_full = 17'(max_q) - 17'(x_q);
	assign prod = acc_q * exp_tab(k_q) + 62'd536870912;
	assign acc_next = prod[60:30];
	assign e_new = 17'((acc_q + 31'd8192) >> 14);

	// gradient arithmetic
	assign diff = 42'(d_q) * 42'sd32768 - 42'(s_q);
	assign t = 59'($signed({1'b0, p_q})) * 59'(diff);
	assign mag = t[58] ? -t : t;
	assign rmag = 30'((mag + 59'd536870912) >> 30);
	assign r = t[58] ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
	assign g = (r > 31'sd32767) ? 16'sd32767 : (r < -31'sd32768) ? -16'sd32768 : r[15:0];

	always_comb begin
		dreq.start = (state_q == S_DIV);
		dreq.e     = e_q;
		dreq.sum   = sum_q;
	end

	smg_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .done(ddone), .quo(dquo));

	// element stores, read through registers at the sequencer index
	always_ff @(posedge clk) begin
		if (acc_ok && cnt_q < CntW'(MaxClasses)) begin
			logit_mem[cnt_q[IdxW-1:0]] <= logit;
			grad_mem[cnt_q[IdxW-1:0]]  <= upstream_grad;
		end
		if (state_q == S_EXPW && k_q == 4'd12)
			e_mem[j_q] <= e_new;
		if (state_q == S_DIVW && ddone)
			p_mem[j_q] <= dquo;
		x_q <= logit_mem[j_q];
		d_q <= grad_mem[j_q];
		e_q <= e_mem[j_q];
		p_q <= p_mem[j_q];
	end

	// sequencer; each *F state lets the read registers catch up with j_q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			n_q        <= '0;
			j_q        <= '0;
			max_q      <= -16'sd32768;
			mode_q     <= 1'b0;
			mode_row_q <= 1'b0;
			acc_q      <= '0;
			a_q        <= '0;
			k_q        <= '0;
			sum_q      <= '0;
			s_q        <= '0;
			strobe     <= 1'b0;
			value      <= '0;
			last       <= 1'b0;
		end else begin
			strobe <= 1'b0;
			if (cfg_we) mode_q <= cfg_wdata;
			case (state_q)
				S_IDLE: begin
					if (acc_ok) begin
						logic [CntW-1:0] nc;
						nc = cnt_q;
						if (cnt_q < CntW'(MaxClasses)) begin
							nc = cnt_q + 1'b1;
							if (logit > max_q) max_q <= logit;
						end
						cnt_q <= nc;
						if (row_end) begin
							n_q <= nc;
							mode_row_q <= mode_q;
							j_q <= '0;
							sum_q <= '0;
							s_q <= '0;
							state_q <= S_EXPF;
						end
					end
				end
				S_EXPF: state_q <= S_EXP;
				S_EXP: begin
					a_q <= a_full[15:0];
					state_q <= S_EXPW;
					if (a_full[16] || a_full[15:12] != 4'd0) begin
						acc_q <= '0;
						k_q <= 4'd12;
					end else begin
						acc_q <= 31'd1073741824;
						k_q <= '0;
					end
				end
				S_EXPW: begin
					if (k_q == 4'd12) begin
						sum_q <= sum_q + 23'(e_new);
						if (last_el) begin
							j_q <= '0;
							state_q <= S_DIVF;
						end else begin
							j_q <= j_q + 1'b1;
							state_q <= S_EXPF;
						end
					end else begin
						if (a_q[k_q]) acc_q <= acc_next;
						k_q <= k_q + 4'd1;
					end
				end
				S_DIVF: state_q <= S_DIV;
				S_DIV: state_q <= S_DIVW;
				S_DIVW: begin
					if (ddone) begin
						if (last_el) begin
							j_q <= '0;
							state_q <= mode_row_q ? S_DOTF : S_OUT;
						end else begin
							j_q <= j_q + 1'b1;
							state_q <= S_DIVF;
						end
					end
				end
				S_DOTF: state_q <= S_DOT;
				S_DOT: begin
					s_q <= s_q + 40'(d_q) * 40'($signed({1'b0, p_q}));
					if (last_el) begin
						j_q <= '0;
						state_q <= S_OUT;
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= S_DOTF;
					end
				end
				S_OUT: state_q <= S_OUTM;
				S_OUTM: begin
					strobe <= 1'b1;
					value <= mode_row_q ? g : $signed(p_q);
					last <= last_el;
					if (last_el) begin
						cnt_q <= '0;
						max_q <= -16'sd32768;
						state_q <= S_IDLE;
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= S_OUT;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_idle_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(MaxClasses)) else $error("count overflow");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> state_q == S_IDLE) else $error("last not at row end");
	a_no_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q) == S_IDLE |-> !strobe) else $error("result while idle");
endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import smg_pkg::*;

	typedef struct {
		logic signed [15:0] value;
		logic               last;
	} softmax_out_t;

	// one directed item; fixed marks a single-element row whose value is known
	typedef struct {
		bit                 md;
		logic signed [15:0] x;
		logic signed [15:0] d;
		bit                 re;
		bit                 fixed;
		logic signed [15:0] v;
	} dir_item_t;

	localparam int WdogLimit = 20000;
	localparam int DrainCycles = 16;
	localparam bit ModeProb = 1'b0;
	localparam bit ModeGrad = 1'b1;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               cfg_we;
	logic               cfg_wdata;
	logic signed [15:0] logit;
	logic signed [15:0] upstream_grad;
	logic               row_end;
	logic               strobe;
	logic signed [15:0] value;
	logic               last;

	softmax_out_t       pending_q[$];
	dir_item_t          dir_tab[$];
	bit                 failed;
	int                 wdog;
	int                 n_items;
	bit                 no_gaps;

	// predictor state
	longint             row_logit[MaxClasses];
	longint             row_grad[MaxClasses];
	int                 row_cnt;
	longint             row_max;
	bit                 cur_mode;

	softmax_with_gradient_unit u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .logit(logit),
		.upstream_grad(upstream_grad), .row_end(row_end),
		.strobe(strobe), .value(value), .last(last)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Q1.16 exp(-a) by table product over the bits of a
	function automatic longint unsigned exp_q16(input longint a);
		longint unsigned acc;
		longint unsigned tv[12];
		begin
			tv = '{1069555701, 1065385899, 1057095000, 1040706261, 1008687096,
				947573834, 836230973, 651257337, 395007542, 145315154,
				19666267, 360200};
			if (a >= 4096)
				return 0;
			acc = 64'd1 << 30;
			for (int k = 0; k < 12; k++)
				if (a[k])
					acc = (acc * tv[k] + (64'd1 << 29)) >> 30;
			return (acc + (64'd1 << 13)) >> 14;
		end
	endfunction

	// store the element; on row end queue the probabilities or gradients
	task automatic predict_item(input logic signed [15:0] x, input logic signed [15:0] d,
			input bit re);
		longint unsigned e[MaxClasses];
		longint          p[MaxClasses];
		longint unsigned sum;
		longint unsigned q;
		longint unsigned mag;
		longint          s;
		longint          t;
		longint          r;
		softmax_out_t    o;
		begin
			if (row_cnt < MaxClasses) begin
				row_logit[row_cnt] = x;
				row_grad[row_cnt] = d;
				row_cnt++;
				if (longint'(x) > row_max)
					row_max = x;
			end
			if (re) begin
				sum = 0;
				for (int j = 0; j < row_cnt; j++) begin
					e[j] = exp_q16(row_max - row_logit[j]);
					sum += e[j];
				end
				s = 0;
				for (int j = 0; j < row_cnt; j++) begin
					q = (e[j] * 32768 + sum / 2) / sum;
					p[j] = (q > 32767) ? 32767 : q;
					s += row_grad[j] * p[j];
				end
				for (int j = 0; j < row_cnt; j++) begin
					if (cur_mode == ModeProb) begin
						o.value = 16'(p[j]);
					end else begin
						t = p[j] * (row_grad[j] * 32768 - s);
						mag = (t < 0) ? -t : t;
						r = (mag + (64'd1 << 29)) >> 30;
						if (t < 0)
							r = -r;
						o.value = 16'((r > 32767) ? 32767 : ((r < -32768) ? -32768 : r));
					end
					o.last = (j + 1 == row_cnt);
					pending_q.push_back(o);
				end
				row_cnt = 0;
				row_max = -32768;
			end
		end
	endtask

	// drive one item at the falling edge and hold it until taken
	task automatic send_item(input logic signed [15:0] x, input logic signed [15:0] d,
			input bit re);
		begin
			if (!no_gaps && $urandom_range(99) < 8) begin
				start = 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
			start = 1'b1;
			logit = x;
			upstream_grad = d;
			row_end = re;
			while (busy)
				@(negedge clk);
			@(posedge clk);
			predict_item(x, d, re);
			n_items++;
			@(negedge clk);
		end
	endtask

	// wait until all results are in, then write the mode register
	task automatic write_mode(input bit m);
		begin
			start = 1'b0;
			while (pending_q.size() != 0)
				@(negedge clk);
			repeat (DrainCycles) @(negedge clk);
			cfg_we = 1'b1;
			cfg_wdata = m;
			@(negedge clk);
			cfg_we = 1'b0;
			cur_mode = m;
		end
	endtask

	// result check
	always @(posedge clk) begin
		softmax_out_t ex;
		if (arst_n && strobe) begin
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result value=%0d last=%0d", $time, value, last);
				failed = 1'b1;
			end else begin
				ex = pending_q.pop_front();
				if (value !== ex.value) begin
					$display("%0t: value expected %0d actual %0d", $time, ex.value, value);
					failed = 1'b1;
				end
				if (last !== ex.last) begin
					$display("%0t: last expected %0d actual %0d", $time, ex.last, last);
					failed = 1'b1;
				end
			end
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (strobe || (start && !busy))
			wdog <= 0;
		else
			wdog <= wdog + 1;
		if (wdog >= WdogLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic signed [15:0] rand_logit();
		logic signed [15:0] v;
		begin
			case ($urandom_range(3))
				0: v = 16'($urandom);
				1: v = 16'($urandom_range(65535));
				default: v = $signed(16'($urandom_range(2047))) - 16'sd1024;
			endcase
			return v;
		end
	endfunction

	task automatic random_row(input int len);
		logic signed [15:0] base;
		begin
			base = 16'($urandom);
			for (int i = 0; i < len; i++)
				if ($urandom_range(1))
					send_item(base - 16'($urandom_range(1500)), 16'($urandom),
						i == len - 1);
				else
					send_item(rand_logit(), 16'($urandom), i == len - 1);
		end
	endtask

	initial begin
		int len;
		int rows;
		softmax_out_t tmp;
		failed = 1'b0;
		wdog = 0;
		n_items = 0;
		no_gaps = 1'b0;
		start = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		logit = '0;
		upstream_grad = '0;
		row_end = 1'b0;
		row_cnt = 0;
		row_max = -32768;
		cur_mode = ModeProb;
		arst_n = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed rows: lone elements, ties, extreme spread, gradient extremes
		dir_tab.push_back('{ModeProb, 16'sd0, 16'sd0, 1, 1, 16'sd32767});
		dir_tab.push_back('{ModeProb, -16'sd32768, 16'sd5, 1, 1, 16'sd32767});
		dir_tab.push_back('{ModeProb, 16'sd32767, -16'sd1, 1, 1, 16'sd32767});
		dir_tab.push_back('{ModeProb, 16'sd256, 16'sd0, 0, 0, 16'sd0});
		dir_tab.push_back('{ModeProb, 16'sd256, 16'sd0, 1, 0, 16'sd0});
		dir_tab.push_back('{ModeProb, 16'sd32767, 16'sd0, 0, 0, 16'sd0});
		dir_tab.push_back('{ModeProb, -16'sd32768, 16'sd0, 1, 0, 16'sd0});
		dir_tab.push_back('{ModeProb, 16'sd100, 16'sd0, 0, 0, 16'sd0});
		dir_tab.push_back('{ModeProb, 16'sd4095, 16'sd0, 0, 0, 16'sd0});
		dir_tab.push_back('{ModeProb, 16'sd4096, 16'sd0, 1, 0, 16'sd0});
		dir_tab.push_back('{ModeGrad, 16'sd0, 16'sd32767, 1, 0, 16'sd0});
		dir_tab.push_back('{ModeGrad, 16'sd0, -16'sd32768, 1, 0, 16'sd0});
		dir_tab.push_back('{ModeGrad, 16'sd0, 16'sd32767, 0, 0, 16'sd0});
		dir_tab.push_back('{ModeGrad, 16'sd0, -16'sd32768, 1, 0, 16'sd0});
		dir_tab.push_back('{ModeGrad, 16'sd512, -16'sd32768, 0, 0, 16'sd0});
		dir_tab.push_back('{ModeGrad, -16'sd512, 16'sd32767, 0, 0, 16'sd0});
		dir_tab.push_back('{ModeGrad, 16'sd0, 16'sd1234, 1, 0, 16'sd0});
		dir_tab.push_back('{ModeGrad, 16'sd32767, -16'sd32768, 0, 0, 16'sd0});
		dir_tab.push_back('{ModeGrad, -16'sd32768, 16'sd32767, 1, 0, 16'sd0});

		foreach (dir_tab[i]) begin
			if (dir_tab[i].md != cur_mode)
				write_mode(dir_tab[i].md);
			send_item(dir_tab[i].x, dir_tab[i].d, dir_tab[i].re);
			if (dir_tab[i].fixed) begin
				tmp = pending_q.pop_back();
				tmp.value = dir_tab[i].v;
				pending_q.push_back(tmp);
			end
		end

		// random rows, mostly short; one full row sent with no gaps and one overflowing row
		rows = 0;
		while (n_items < 170) begin
			if (rows % 6 == 5)
				write_mode($urandom_range(1));
			no_gaps = (rows >= 2 && rows < 6);
			if (rows == 3)
				len = MaxClasses;
			else if (rows == 8)
				len = MaxClasses + $urandom_range(1, 5);
			else
				len = $urandom_range(1, 8);
			random_row(len);
			rows++;
		end
		write_mode(ModeProb);

		start = 1'b0;
		while (pending_q.size() != 0)
			@(negedge clk);
		repeat (DrainCycles) @(negedge clk);
		if (!failed && pending_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
